/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/cvc_pkg.sv */
// ----------------------------------------------------------------------------
// cvc_pkg
// Types and constants of the consensus vote checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvc_pkg;

  localparam int CFG_W     = 5;
  localparam int OUT_CNT_W = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  typedef struct packed {
    logic faulty;
    logic ref_vote;
  } cvc_entry_t;

endpackage

/* hw/rtl/consensus_vote_checker_core.sv */
// ----------------------------------------------------------------------------
// consensus_vote_checker_core
// Majority vote over an N by N table of gathered votes with per-column
// consistency check against row zero.
//
//   channel | dir | tdata fields (low bit up)
//   --------+-----+------------------------------------------------------------
//   in_     | in  | vote[0]
//   out_    | out | decision[0] for_count[5:1] against_count[10:6]
//           |     | ignored_count[15:11]
//   cfg_    | in  | voter_count[4:0], written when cfg_we is high
//
// One vote per cycle while in_tready is high. The last vote of a table is
// registered into the update stage, whose emit fills the output register and
// raises out_tvalid. Each vote reads its column entry at accept and writes it
// back as the update stage advances; a write to the entry being read is
// forwarded. in_tready drops only while a finished result waits untaken in
// the output register and the vote in the update stage closes another table.
// Reset clears positions, counts and valid flags; the column memory needs no
// clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module consensus_vote_checker_core #(
  parameter int MAX_VOTERS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cvc_pkg::IN_DATA_W-1:0]    in_tdata,   // vote[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cvc_pkg::OUT_DATA_W-1:0]   out_tdata,  // decision, for, against, ignored
  input  logic                             cfg_we,
  input  logic [cvc_pkg::CFG_W-1:0]        cfg_wdata
);
  import cvc_pkg::*;

  localparam int PW = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
  localparam int NW = $clog2(MAX_VOTERS + 1);
  localparam int KW = NW;

  logic [CFG_W-1:0] cfg_r;
  logic [NW-1:0]    n_eff;

  logic [PW-1:0] row_r, col_r;
  logic          last_row, last_col;
  logic          in_fire;
  logic          in_vote;

  cvc_entry_t    mem [MAX_VOTERS];
  cvc_entry_t    rd_r;
  cvc_entry_t    fwd_r;
  logic          fwd_hit_r;

  logic          s1_valid_r;
  logic [PW-1:0] s1_col_r;
  logic          s1_vote_r;
  logic          s1_row0_r;
  logic          s1_last_row_r;
  logic          s1_end_r;

  cvc_entry_t    s1_old, s1_new;
  logic          s1_stall, s1_adv, s1_emit;

  logic [KW-1:0] cnt_for_r, cnt_against_r, cnt_ignored_r;
  logic [KW-1:0] cnt_for_nxt, cnt_against_nxt, cnt_ignored_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  decision;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_r) > MAX_VOTERS) begin
      n_eff = NW'(MAX_VOTERS);
    end else begin
      n_eff = NW'(cfg_r);
    end
  end

  assign in_vote  = in_tdata[0];
  assign last_row = (32'(row_r) + 32'd1) >= 32'(n_eff);
  assign last_col = (32'(col_r) + 32'd1) >= 32'(n_eff);

  assign s1_stall  = s1_valid_r && s1_end_r && out_valid_r && !out_tready;
  assign s1_adv    = s1_valid_r && !s1_stall;
  assign s1_emit   = s1_adv && s1_end_r;
  assign in_tready = !s1_stall;
  assign in_fire   = in_tvalid && in_tready;

  // advance table position at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + PW'(1);
      end else begin
        col_r <= col_r + PW'(1);
      end
    end
  end

  // column memory: read at accept, write back from the update stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_col_r] <= s1_new;
    end
    if (in_fire) begin
      rd_r <= mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= s1_adv && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r         <= s1_new;
      s1_col_r      <= col_r;
      s1_vote_r     <= in_vote;
      s1_row0_r     <= (row_r == '0);
      s1_last_row_r <= last_row;
      s1_end_r      <= last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_comb begin
    s1_old = fwd_hit_r ? fwd_r : rd_r;
    s1_new = s1_old;
    if (s1_row0_r) begin
      s1_new.ref_vote = s1_vote_r;
      s1_new.faulty   = 1'b0;
    end else if (s1_old.ref_vote != s1_vote_r) begin
      s1_new.faulty = 1'b1;
    end
  end

  always_comb begin
    cnt_for_nxt     = cnt_for_r;
    cnt_against_nxt = cnt_against_r;
    cnt_ignored_nxt = cnt_ignored_r;
    if (s1_last_row_r) begin
      if (s1_new.faulty) begin
        cnt_ignored_nxt = cnt_ignored_r + KW'(1);
      end else if (s1_new.ref_vote) begin
        cnt_for_nxt = cnt_for_r + KW'(1);
      end else begin
        cnt_against_nxt = cnt_against_r + KW'(1);
      end
    end
  end

  assign decision = ({1'b0, cnt_for_nxt}) >
                    ({1'b0, cnt_against_nxt} + {1'b0, cnt_ignored_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_for_r     <= '0;
      cnt_against_r <= '0;
      cnt_ignored_r <= '0;
    end else if (s1_adv) begin
      if (s1_end_r) begin
        cnt_for_r     <= '0;
        cnt_against_r <= '0;
        cnt_ignored_r <= '0;
      end else begin
        cnt_for_r     <= cnt_for_nxt;
        cnt_against_r <= cnt_against_nxt;
        cnt_ignored_r <= cnt_ignored_nxt;
      end
    end
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_data_r <= {OUT_CNT_W'(cnt_ignored_nxt), OUT_CNT_W'(cnt_against_nxt),
                     OUT_CNT_W'(cnt_for_nxt), decision};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_NEXT(a_fire_loads_stage, clk, rst_n, in_fire, s1_valid_r)
  `ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, s1_stall,
               s1_valid_r && s1_end_r && $stable(s1_col_r))
  `ASSERT_NEXT(a_emit_fills_output, clk, rst_n, s1_emit, out_valid_r)
  `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, s1_stall,
                  out_valid_r && !in_tready)

endmodule
